/* rtl/ttps_pkg.sv */
// ttps_pkg: shared types and constants for the transposition table block
// item, result and table entry structs, operation, bound and config codes, mate limit
// no dependencies
package ttps_pkg;

    localparam int MATE_SCORE = 30000;

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam logic [1:0] CFG_TABLE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SIZE_LOG2    = 2'd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [6:0]         ply;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [15:0]        move_found;
        logic               cutoff;
        logic signed [15:0] score_out;
        logic               stored;
    } t_result;

    // one table slot as seen by the evaluation logic
    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [6:0]         depth;
        logic [1:0]         bound;
        logic [15:0]        move;
    } t_entry;

endpackage

/* rtl/ttps_mem.sv */
// ttps_mem: single write port, single read port synchronous table memory
// read data registered on the read enable; uses no package items
module ttps_mem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 105
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [0:(2**ADDR_W)-1];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ttps_eval.sv */
// ttps_eval: probe hit, cutoff and store decision for one item against its slot
// mate score shift by ply on read and write, store saturation; uses ttps_pkg
module ttps_eval #(
    parameter int PLY_LIMIT = 128
) (
    input  logic             i_enable,
    input  ttps_pkg::t_item  i_item,
    input  ttps_pkg::t_entry i_ent,
    output ttps_pkg::t_result o_result,
    output logic             o_write,
    output ttps_pkg::t_entry o_wr_ent
);
    import ttps_pkg::*;

    localparam logic signed [17:0] MATE_HI = 18'(MATE_SCORE - PLY_LIMIT);
    localparam logic signed [17:0] MATE_LO = 18'(PLY_LIMIT - MATE_SCORE);
    localparam logic signed [17:0] SAT_HI  = 18'sd32767;
    localparam logic signed [17:0] SAT_LO  = -18'sd32768;

    logic               hit;
    logic signed [17:0] ply_s;
    logic signed [17:0] rd_v;
    logic signed [17:0] rd_adj;
    logic signed [17:0] wr_v;
    logic signed [17:0] wr_adj;
    logic signed [15:0] wr_sat;
    logic               bound_ok;
    logic               skip;

    assign hit   = (i_ent.key == i_item.key);
    assign ply_s = $signed({11'd0, i_item.ply});

    // mate scores move towards the root on read
    always_comb begin
        rd_v = 18'(i_ent.score);
        if (rd_v > MATE_HI) begin
            rd_adj = rd_v - ply_s;
        end else if (rd_v < MATE_LO) begin
            rd_adj = rd_v + ply_s;
        end else begin
            rd_adj = rd_v;
        end
    end

    always_comb begin
        case (i_ent.bound)
            BOUND_EXACT: bound_ok = 1'b1;
            BOUND_LOWER: bound_ok = (rd_adj >= 18'(i_item.beta));
            BOUND_UPPER: bound_ok = (rd_adj <= 18'(i_item.alpha));
            default:     bound_ok = 1'b0;
        endcase
    end

    // and away from it on write, clamped to the score width
    always_comb begin
        wr_v = 18'(i_item.score);
        if (wr_v > MATE_HI) begin
            wr_adj = wr_v + ply_s;
        end else if (wr_v < MATE_LO) begin
            wr_adj = wr_v - ply_s;
        end else begin
            wr_adj = wr_v;
        end
        if (wr_adj > SAT_HI) begin
            wr_sat = 16'sh7fff;
        end else if (wr_adj < SAT_LO) begin
            wr_sat = -16'sh8000;
        end else begin
            wr_sat = wr_adj[15:0];
        end
    end

    assign skip = hit && (i_ent.depth > i_item.depth) && (i_item.bound != BOUND_EXACT);

    always_comb begin
        o_result = '0;
        o_write  = 1'b0;
        if (i_enable) begin
            case (i_item.kind)
                KIND_PROBE: begin
                    if (hit) begin
                        o_result.found      = 1'b1;
                        o_result.move_found = i_ent.move;
                        o_result.score_out  = rd_adj[15:0];
                        o_result.cutoff     = (i_ent.depth >= i_item.depth) && bound_ok;
                    end
                end
                KIND_STORE: begin
                    o_result.stored = !skip;
                    o_write         = !skip;
                end
                default: begin
                    o_result = '0;
                end
            endcase
        end
    end

    always_comb begin
        o_wr_ent.key   = i_item.key;
        o_wr_ent.score = wr_sat;
        o_wr_ent.depth = i_item.depth;
        o_wr_ent.bound = i_item.bound;
        o_wr_ent.move  = i_item.move;
    end

endmodule

/* rtl/transposition_table_probe_store.sv */
// transposition_table_probe_store: direct-mapped table, probe / store / clear.
// an accepted item's slot is read as the block enters S_EVAL, where the write back is made and the
// result strobe registered; busy is high for one cycle there but for an enabled clear, so no new item meanwhile.
// an enabled clear, and reset, sweep all 2**INDEX_BITS slots to zero, one a cycle, busy meanwhile.
// reset is synchronous, active low; the result cannot be stalled by the receiver.
// uses ttps_pkg, ttps_mem, ttps_eval
module transposition_table_probe_store #(
    parameter int INDEX_BITS = 16,
    parameter int PLY_LIMIT  = 128,
    parameter int MOVE_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ttps_pkg::t_item   i_item,
    output logic              o_done,
    output ttps_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [4:0]        i_cfg_data
);
    import ttps_pkg::*;

    localparam int MV_W    = (MOVE_BITS < 16) ? MOVE_BITS : 16;
    localparam int ENTRY_W = 64 + 16 + 7 + 2 + MV_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_SWEEP = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [INDEX_BITS-1:0] r_sweep, n_sweep;
    logic                  r_enable;
    logic [4:0]            r_size;
    t_item                 r_item;
    logic [INDEX_BITS-1:0] r_idx;
    logic                  r_done, n_done;
    t_result               r_result;

    logic                  accept;
    logic [INDEX_BITS-1:0] idx;
    logic [ENTRY_W-1:0]    rd_data;
    t_entry                rd_ent;
    t_result               ev_result;
    logic                  ev_write;
    t_entry                wr_ent;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // slot index: key masked to the live size, clamped by the physical size
    always_comb begin
        for (int j = 0; j < INDEX_BITS; j++) begin
            idx[j] = i_item.key[j] && (5'(j) < r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_size   <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TABLE_ENABLE: r_enable <= i_cfg_data[0];
                CFG_SIZE_LOG2:    r_size   <= i_cfg_data;
                default:          r_size   <= r_size;
            endcase
        end
    end

    ttps_mem #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        rd_ent.key   = rd_data[ENTRY_W-1 -: 64];
        rd_ent.score = rd_data[ENTRY_W-65 -: 16];
        rd_ent.depth = rd_data[ENTRY_W-81 -: 7];
        rd_ent.bound = rd_data[MV_W+1 -: 2];
        rd_ent.move  = 16'(rd_data[MV_W-1:0]);
    end

    ttps_eval #(
        .PLY_LIMIT (PLY_LIMIT)
    ) u_eval (
        .i_enable (r_enable),
        .i_item   (r_item),
        .i_ent    (rd_ent),
        .o_result (ev_result),
        .o_write  (ev_write),
        .o_wr_ent (wr_ent)
    );

    always_comb begin
        if (r_state == S_SWEEP) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep;
            wr_data = '0;
        end else begin
            wr_en   = (r_state == S_EVAL) && ev_write;
            wr_addr = r_idx;
            wr_data = {wr_ent.key, wr_ent.score, wr_ent.depth, wr_ent.bound,
                       wr_ent.move[MV_W-1:0]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_done = 1'b1;
                if (r_enable && (r_item.kind == KIND_CLEAR)) begin
                    n_state = S_SWEEP;
                    n_sweep = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                n_sweep = r_sweep + INDEX_BITS'(1);
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_idx  <= idx;
        end
        if (r_state == S_EVAL) begin
            r_result <= ev_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/ttps_chk.sv */
// ttps_chk: port-level checks on transaction timing and result consistency
// bound to transposition_table_probe_store; uses ttps_pkg
module ttps_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input ttps_pkg::t_result o_result
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing two cycles after accept");

    a_done_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in the previous cycle");

    a_cutoff_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.cutoff) |-> o_result.found)
        else $error("cutoff reported on a miss");

    a_store_no_probe_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.stored) |-> (!o_result.found && !o_result.cutoff))
        else $error("store result carries probe fields");

endmodule

bind transposition_table_probe_store ttps_chk u_ttps_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for transposition_table_probe_store, directed table then random traffic
// each transaction is scored against a local model of the slot table and its two registers, or a fixed expectation
// depends on ttps_pkg and the block rtl

module tb;
    import ttps_pkg::*;

    localparam int INDEX_BITS   = 16;
    localparam int PLY_LIMIT    = 128;
    localparam int MOVE_BITS    = 16;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASES       = 8;

    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam logic [1:0] BOUND_UNUSED = 2'd3;

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_index;
        logic [4:0] cfg_data;
        t_item      item;
        bit         fixed;
        t_result    want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    // local copy of the slot table; a slot never written reads as all zero
    t_entry     slot_mem [int unsigned];
    bit         tt_enable;
    logic [4:0] tt_size_log2;

    t_result    results_pending [$];
    t_row       stim_table [$];
    logic [63:0] key_pool [$];
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         clears_left = 4;

    bit         phase_enable [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
    logic [4:0] phase_size   [PHASES] = '{0, 1, 4, 4, 16, 31, 20, 8};

    transposition_table_probe_store #(
        .INDEX_BITS (INDEX_BITS),
        .PLY_LIMIT  (PLY_LIMIT),
        .MOVE_BITS  (MOVE_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_result tt_lookup_update(t_item it);
        t_result     r;
        t_entry      e;
        int unsigned slot;
        int          bits;
        int          v;
        r = '0;
        e = '0;
        bits = (tt_size_log2 > INDEX_BITS) ? INDEX_BITS : int'(tt_size_log2);
        slot = 32'(it.key & ((64'd1 << bits) - 64'd1));
        if (slot_mem.exists(slot)) e = slot_mem[slot];
        if (tt_enable && it.kind == KIND_PROBE) begin
            if (e.key == it.key) begin
                r.found = 1'b1;
                r.move_found = e.move;
                v = $signed(e.score);
                // mate distances are kept relative to the stored node
                if (v > MATE_SCORE - PLY_LIMIT) v = v - int'(it.ply);
                else if (v < -MATE_SCORE + PLY_LIMIT) v = v + int'(it.ply);
                r.score_out = 16'(v);
                if (e.depth >= it.depth) begin
                    if (e.bound == BOUND_EXACT) r.cutoff = 1'b1;
                    else if (e.bound == BOUND_LOWER && v >= $signed(it.beta)) r.cutoff = 1'b1;
                    else if (e.bound == BOUND_UPPER && v <= $signed(it.alpha)) r.cutoff = 1'b1;
                end
            end
        end else if (tt_enable && it.kind == KIND_STORE) begin
            // a deeper entry for the same position is kept unless the new one is exact
            if (!(e.key == it.key && e.depth > it.depth && it.bound != BOUND_EXACT)) begin
                v = $signed(it.score);
                if (v > MATE_SCORE - PLY_LIMIT) v = v + int'(it.ply);
                else if (v < -MATE_SCORE + PLY_LIMIT) v = v - int'(it.ply);
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                e.key   = it.key;
                e.score = 16'(v);
                e.depth = it.depth;
                e.bound = it.bound;
                e.move  = it.move;
                slot_mem[slot] = e;
                r.stored = 1'b1;
            end
        end else if (tt_enable && it.kind == KIND_CLEAR) begin
            slot_mem.delete();
        end
        return r;
    endfunction

    function automatic t_item op(logic [1:0] kind, logic [63:0] key, int depth, int alpha,
                                 int beta, int ply, int score, logic [1:0] bound, int move);
        t_item it;
        it.kind  = kind;
        it.key   = key;
        it.depth = 7'(depth);
        it.alpha = 16'(alpha);
        it.beta  = 16'(beta);
        it.ply   = 7'(ply);
        it.score = 16'(score);
        it.bound = bound;
        it.move  = 16'(move);
        return it;
    endfunction

    function automatic t_result outcome(bit found, int move, bit cutoff, int score, bit stored);
        t_result r;
        r.found      = found;
        r.move_found = 16'(move);
        r.cutoff     = cutoff;
        r.score_out  = 16'(score);
        r.stored     = stored;
        return r;
    endfunction

    function automatic void push_op(t_item it, bit fixed, t_result want);
        t_row row;
        row = '{is_cfg: 1'b0, cfg_index: '0, cfg_data: '0, item: it, fixed: fixed, want: want};
        stim_table.push_back(row);
    endfunction

    function automatic void push_cfg(logic [1:0] index, logic [4:0] data);
        t_row row;
        row = '{is_cfg: 1'b1, cfg_index: index, cfg_data: data, item: '0, fixed: 1'b0, want: '0};
        stim_table.push_back(row);
    endfunction

    function automatic logic [15:0] pick_score();
        int r;
        int v;
        r = $urandom_range(9, 0);
        if (r < 5) v = int'($urandom_range(2000, 0)) - 1000;
        else if (r < 8) v = ($urandom_range(1, 0) ? 1 : -1) * int'($urandom_range(32000, 29800));
        else v = int'($urandom_range(64000, 0)) - 32000;
        return 16'(v);
    endfunction

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        int          r;
        k = key_pool[$urandom_range(key_pool.size() - 1, 0)];
        r = $urandom_range(9, 0);
        // same slot under a different key, above and beyond the index bits, or a small or fully random key
        if (r == 5) k = k ^ {40'd0, 8'($urandom_range(255, 1)), 16'd0};
        else if (r == 6) k = k ^ {32'($urandom) | 32'd1, 32'd0};
        else if (r == 7) k = 64'($urandom_range(3, 0));
        else if (r >= 8) k = {$urandom, $urandom};
        return k;
    endfunction

    function automatic t_item random_op();
        t_item it;
        int    r;
        r = $urandom_range(99, 0);
        if (r < 47) it.kind = KIND_PROBE;
        else if (r < 95) it.kind = KIND_STORE;
        else if (r < 99) it.kind = KIND_NONE;
        else if (clears_left > 0) begin
            it.kind = KIND_CLEAR;
            clears_left--;
        end else it.kind = KIND_PROBE;
        it.key   = pick_key();
        it.depth = $urandom_range(1, 0) ? 7'($urandom_range(8, 0)) : 7'($urandom_range(127, 0));
        it.alpha = pick_score();
        it.beta  = pick_score();
        it.ply   = 7'($urandom_range(127, 0));
        it.score = pick_score();
        it.bound = ($urandom_range(19, 0) == 0) ? BOUND_UNUSED : 2'($urandom_range(2, 0));
        it.move  = 16'($urandom_range(65535, 0));
        return it;
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    task automatic issue_op(t_item it, bit fixed, t_result want, int gap);
        t_result predicted;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = tt_lookup_update(it);
        results_pending.push_back(fixed ? want : predicted);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (results_pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [4:0] data);
        drain_results();
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == CFG_TABLE_ENABLE) tt_enable = data[0];
        else if (index == CFG_SIZE_LOG2) tt_size_log2 = data;
    endtask

    task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (results_pending.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got %p", $time, o_result);
            end else begin
                want = results_pending.pop_front();
                report_field("found", want.found, o_result.found);
                report_field("move_found", want.move_found, o_result.move_found);
                report_field("cutoff", want.cutoff, o_result.cutoff);
                report_field("score_out", want.score_out, o_result.score_out);
                report_field("stored", want.stored, o_result.stored);
            end
        end
    end

    initial begin
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        t_result     empty;
        bit          steady;
        k1 = 64'hFFFF_FFFF_FFFF_FFFF;
        k2 = 64'h8000_0000_0000_1234;
        k3 = 64'h0123_4567_89AB_0042;
        empty = '0;

        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        tt_enable    = 1'b0;
        tt_size_log2 = 5'd16;

        // table off after reset: everything misses or is dropped
        push_op(op(KIND_PROBE, 64'd0, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 1, empty);
        push_op(op(KIND_STORE, k2, 9, 0, 0, 3, 500, BOUND_EXACT, 77), 1, empty);
        push_op(op(KIND_CLEAR, 64'd0, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 1, empty);
        push_cfg(CFG_TABLE_ENABLE, 5'd1);
        // an empty slot holds key zero, so key zero hits
        push_op(op(KIND_PROBE, 64'd0, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 1, outcome(1, 0, 1, 0, 0));
        push_op(op(KIND_NONE, k1, 127, -1, -1, 127, -1, BOUND_UNUSED, 65535), 1, empty);
        push_op(op(KIND_STORE, k1, 127, 0, 0, 127, 32000, BOUND_LOWER, 65535), 1,
                outcome(0, 0, 0, 0, 1));
        push_op(op(KIND_PROBE, k1, 127, -32000, 32000, 127, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_STORE, k1, 5, 0, 0, 0, 100, BOUND_UPPER, 1), 0, empty);
        push_op(op(KIND_STORE, k1, 5, 0, 0, 0, 0, BOUND_EXACT, 2), 0, empty);
        push_op(op(KIND_PROBE, k1, 6, 0, 0, 0, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_STORE, k2, 10, 0, 0, 100, -32000, BOUND_UPPER, 4660), 0, empty);
        push_op(op(KIND_PROBE, k2, 10, -32000, 32000, 0, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_PROBE, k2 ^ {1'b1, 63'd0}, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 0, empty);
        // shifted mate scores beyond the 16-bit range saturate
        push_op(op(KIND_STORE, k3, 0, 0, 0, 127, 32767, BOUND_UNUSED, 43690), 0, empty);
        push_op(op(KIND_PROBE, k3, 0, 32000, -32000, 0, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_STORE, k3, 0, 0, 0, 127, -32768, BOUND_LOWER, 21845), 0, empty);
        push_op(op(KIND_PROBE, k3, 0, 32000, -32000, 127, 0, BOUND_EXACT, 0), 0, empty);
        // either side of the mate threshold
        push_op(op(KIND_STORE, k1, 20, 0, 0, 1, 29873, BOUND_EXACT, 3), 0, empty);
        push_op(op(KIND_PROBE, k1, 20, 0, 0, 50, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_STORE, k2, 20, 0, 0, 1, -29872, BOUND_LOWER, 5), 0, empty);
        push_op(op(KIND_PROBE, k2, 3, 0, -29872, 50, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_CLEAR, 64'd0, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 1, empty);
        push_op(op(KIND_PROBE, k1, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 0, empty);
        push_op(op(KIND_PROBE, 64'd0, 0, 0, 0, 0, 0, BOUND_EXACT, 0), 1, outcome(1, 0, 1, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[n]) begin
            if (stim_table[n].is_cfg)
                write_reg(stim_table[n].cfg_index, stim_table[n].cfg_data);
            else
                issue_op(stim_table[n].item, stim_table[n].fixed, stim_table[n].want,
                         pick_gap(1'b0));
        end

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_TABLE_ENABLE, 5'(phase_enable[p]));
            write_reg(CFG_SIZE_LOG2, phase_size[p]);
            key_pool.delete();
            for (int j = 0; j < 10; j++) begin
                if (j < 2) key_pool.push_back({$urandom, 16'($urandom), 16'd0});
                else key_pool.push_back({$urandom, $urandom});
            end
            steady = ($urandom_range(2, 0) == 0);
            for (int j = 0; j < RANDOM_ITEMS / PHASES; j++)
                issue_op(random_op(), 1'b0, empty, pick_gap(steady));
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
